// ===== rtl/core/b64e_pkg.sv =====
// Package: shared types, constants and the base64 alphabet for the stream encoder.
package b64e_pkg;

    localparam int LenBits  = 16;
    localparam int QDepth   = 2;
    localparam int QPtrBits = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int QCntBits = $clog2(QDepth + 1);

    localparam logic [7:0]         PadChar  = 8'h3D;
    localparam logic [LenBits-1:0] CapReset = {LenBits{1'b1}};

    typedef enum logic [1:0] {
        PH_0,
        PH_1,
        PH_2
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_item;

    typedef struct packed {
        logic [7:0]         out_char;
        logic               run_end;
        logic               message_end;
        logic               overflow;
        logic [LenBits-1:0] encoded_length;
    } t_out_item;

    // One accepted byte, fully classified: up to four characters plus an
    // optional terminator or error result.
    typedef struct packed {
        logic [3:0][7:0]    chars;
        logic [2:0]         n_chars;
        logic               has_tail;
        logic               tail_err;
        logic [LenBits-1:0] length;
    } t_job;

    function automatic logic [7:0] b64_char(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd26) begin
            c = 8'h41 + {2'b00, s};
        end else if (s < 6'd52) begin
            c = 8'h61 + {2'b00, s - 6'd26};
        end else if (s < 6'd62) begin
            c = 8'h30 + {2'b00, s - 6'd52};
        end else if (s == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

// ===== rtl/core/base64_stream_encoder.sv =====
// Top level of the streaming base64 encoder: front end, job queue, result sequencer.
//
// Streaming base64 encoder (standard alphabet, '=' padding). Bytes arrive one
// per transfer with final_byte marking the last byte of a message. Each byte
// yields one or two characters; the final byte also yields the flush character,
// padding and a terminator result carrying the encoded length. The capacity
// register bounds the output including the terminator slot; running out gives
// one error result and the rest of the message is dropped up to its final byte.
// Rate: the front end takes one byte per cycle while the two-entry job queue
// has room; the back end sends one result per cycle from its output register
// while the receiver does not stall. A byte yields 1 or 2 results as a middle
// byte, up to 5 as a final byte, and none when dropped. The single-result
// output port sets the sustained rate on long messages. Capacity writes are
// always ready and take effect on the next cycle; write only while the block
// is idle.
module base64_stream_encoder import b64e_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // byte input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    // result output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    // capacity register write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [LenBits-1:0] i_cfg_data
);

    logic q_full;
    logic q_valid;
    logic q_push;
    logic q_pop;
    t_job push_job;
    t_job head_job;

    // stall straight from the registered queue fill level
    assign o_in_stall  = q_full;
    assign o_cfg_ready = 1'b1;

    b64e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .i_q_full    (q_full),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_push      (q_push),
        .o_job       (push_job)
    );

    b64e_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (head_job)
    );

    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (head_job),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== rtl/core/b64e_queue.sv =====
// Short job queue between the classifier front end and the result sequencer.
module b64e_queue import b64e_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_job o_job
);

    t_job                r_mem [QDepth];
    logic [QPtrBits-1:0] r_wp;
    logic [QPtrBits-1:0] r_rp;
    logic [QCntBits-1:0] r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_cnt == QCntBits'(QDepth));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPtrBits'(QDepth - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPtrBits'(QDepth - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/core/b64e_front.sv =====
// Front end: takes bytes, tracks phase/carry/count, classifies each byte into a job.
module b64e_front import b64e_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  t_in_item           i_in_data,
    input  logic               i_q_full,
    input  logic               i_cfg_valid,
    input  logic [LenBits-1:0] i_cfg_data,
    output logic               o_push,
    output t_job               o_job
);

    t_phase             r_phase;
    logic [3:0]         r_carry;
    logic [LenBits-1:0] r_cw;
    logic               r_dropping;
    logic [LenBits-1:0] r_cap;

    t_phase             n_phase;
    logic [3:0]         n_carry;
    logic [5:0]         s0;
    logic [5:0]         s1;
    logic [2:0]         n_main;
    logic [2:0]         n_flush_total;
    logic [2:0]         need;
    logic [2:0]         slots;
    logic [LenBits-1:0] avail;
    logic [2:0]         avail_c;
    logic               err;
    logic               accept;
    logic [7:0]         b;
    logic               fin;

    assign b      = i_in_data.data_byte;
    assign fin    = i_in_data.final_byte;
    assign accept = i_in_valid & ~i_q_full;

    always_comb begin
        unique case (r_phase)
            PH_1: begin
                s0            = {r_carry[1:0], b[7:4]};
                s1            = {b[3:0], 2'b00};
                n_main        = 3'd1;
                n_flush_total = 3'd3;
                n_phase       = PH_2;
                n_carry       = b[3:0];
            end
            PH_2: begin
                s0            = {r_carry, b[7:6]};
                s1            = b[5:0];
                n_main        = 3'd2;
                n_flush_total = 3'd2;
                n_phase       = PH_0;
                n_carry       = 4'd0;
            end
            default: begin
                s0            = b[7:2];
                s1            = {b[1:0], 4'b0000};
                n_main        = 3'd1;
                n_flush_total = 3'd4;
                n_phase       = PH_1;
                n_carry       = {2'b00, b[1:0]};
            end
        endcase

        need  = fin ? n_flush_total : n_main;
        slots = need + {2'b00, fin};     // terminator takes a slot too
        avail = (r_cw < r_cap) ? r_cap - r_cw : '0;
        avail_c = (avail >= LenBits'(5)) ? 3'd5 : avail[2:0];
        err   = (avail_c < slots);

        o_job.chars[0] = b64_char(s0);
        o_job.chars[1] = b64_char(s1);
        o_job.chars[2] = PadChar;
        o_job.chars[3] = PadChar;
        o_job.n_chars  = err ? avail_c : need;
        o_job.has_tail = err | fin;
        o_job.tail_err = err;
        o_job.length   = r_cw + LenBits'(need);
    end

    assign o_push = accept & ~r_dropping;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CapReset;
        end else if (i_cfg_valid) begin
            r_cap <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_0;
            r_carry    <= '0;
            r_cw       <= '0;
            r_dropping <= 1'b0;
        end else if (accept) begin
            if (r_dropping) begin
                if (fin) begin
                    r_dropping <= 1'b0;
                end
            end else if (err || fin) begin
                r_phase    <= PH_0;
                r_carry    <= '0;
                r_cw       <= '0;
                r_dropping <= err & ~fin;
            end else begin
                r_phase <= n_phase;
                r_carry <= n_carry;
                r_cw    <= r_cw + LenBits'(n_main);
            end
        end
    end

endmodule

// ===== rtl/core/b64e_back.sv =====
// Back end: walks the head job one result per cycle into the output register, unless stalled.
module b64e_back import b64e_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_valid,
    input  t_job      i_job,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    logic [2:0] r_idx;
    logic       r_valid;
    t_out_item  r_out;

    logic [2:0] total;
    logic       last;
    logic       load;
    t_out_item  res;

    always_comb begin
        total = i_job.n_chars + {2'b00, i_job.has_tail};
        last  = (r_idx == total - 3'd1);
        load  = i_q_valid & (~r_valid | ~i_out_stall);

        if (r_idx < i_job.n_chars) begin
            res.out_char       = i_job.chars[r_idx[1:0]];
            res.message_end    = 1'b0;
            res.overflow       = 1'b0;
            res.encoded_length = '0;
        end else begin
            res.out_char       = 8'h00;
            res.message_end    = 1'b1;
            res.overflow       = i_job.tail_err;
            res.encoded_length = i_job.tail_err ? '0 : i_job.length;
        end
        res.run_end = last;
    end

    assign o_pop       = load & last;
    assign o_out_valid = r_valid;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= last ? 3'd0 : r_idx + 3'd1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// ===== dv/tb_base64_stream_encoder.sv =====
// Testbench for base64_stream_encoder: directed and random byte streams checked by a predictor.
`timescale 1ns / 100ps

module tb_base64_stream_encoder;
    import b64e_pkg::*;

    localparam int unsigned DRAIN_CYCLES = 8;    // settle time once nothing is expected
    localparam int unsigned HOLD_CYCLES  = 400;  // long receiver hold-off
    localparam int unsigned PHASE_BYTES  = 14;   // minimum bytes per random phase

    localparam bit [0:63][7:0] B64_ALPHABET =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_in_item           i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out_item          o_out_data;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [LenBits-1:0] i_cfg_data  = '0;

    base64_stream_encoder dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Encoder shadow state
    t_phase             enc_phase    = PH_0;
    logic [3:0]         enc_carry    = '0;
    logic [LenBits-1:0] enc_count    = '0;
    bit                 enc_dropping = 1'b0;
    logic [LenBits-1:0] capacity_q   = CapReset;

    t_out_item exp_results[$];

    int unsigned in_idle_pct   = 0;
    int unsigned out_stall_pct = 0;
    int unsigned hold_asked    = 0;
    int unsigned hold_taken    = 0;
    int unsigned hold_left     = 0;

    int unsigned mismatches    = 0;
    int unsigned bytes_sent    = 0;
    int unsigned msgs_sent     = 0;
    int unsigned results_seen  = 0;
    int unsigned terms_seen    = 0;
    int unsigned errors_seen   = 0;
    int unsigned cfg_writes    = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic void push_result(input logic [7:0] ch, input bit msg_end,
                                        input bit ovf, input logic [LenBits-1:0] len);
        t_out_item r;
        r.out_char       = ch;
        r.run_end        = 1'b0;
        r.message_end    = msg_end;
        r.overflow       = ovf;
        r.encoded_length = len;
        exp_results.push_back(r);
    endfunction

    // One output slot: a character if capacity allows, else the error result.
    function automatic bit emit_char(input logic [7:0] ch);
        if (enc_count >= capacity_q) begin
            push_result(8'h00, 1'b1, 1'b1, '0);
            return 1'b0;
        end
        push_result(ch, 1'b0, 1'b0, '0);
        enc_count = enc_count + 1'b1;
        return 1'b1;
    endfunction

    function automatic void clear_message();
        enc_phase = PH_0;
        enc_carry = '0;
        enc_count = '0;
    endfunction

    function automatic void encode_byte(input t_in_item it);
        logic [7:0] b;
        bit         fin;
        bit         ok;
        int         mark;
        t_out_item  last;
        b    = it.data_byte;
        fin  = it.final_byte;
        ok   = 1'b1;
        mark = exp_results.size();

        // rest of a failed message is swallowed, final byte included
        if (enc_dropping) begin
            if (fin)
                enc_dropping = 1'b0;
            return;
        end

        case (enc_phase)
            PH_1: begin
                ok        = emit_char(B64_ALPHABET[{enc_carry[1:0], b[7:4]}]);
                enc_carry = b[3:0];
                enc_phase = PH_2;
            end
            PH_2: begin
                ok = emit_char(B64_ALPHABET[{enc_carry, b[7:6]}]);
                if (ok)
                    ok = emit_char(B64_ALPHABET[b[5:0]]);
                enc_carry = '0;
                enc_phase = PH_0;
            end
            default: begin
                ok        = emit_char(B64_ALPHABET[b[7:2]]);
                enc_carry = {2'b00, b[1:0]};
                enc_phase = PH_1;
            end
        endcase

        if (ok && fin) begin
            // flush the partial sextet and pad up to a full quad
            if (enc_phase == PH_1) begin
                ok = emit_char(B64_ALPHABET[{enc_carry[1:0], 4'b0000}]);
                if (ok) ok = emit_char(PadChar);
                if (ok) ok = emit_char(PadChar);
            end else if (enc_phase == PH_2) begin
                ok = emit_char(B64_ALPHABET[{enc_carry, 2'b00}]);
                if (ok) ok = emit_char(PadChar);
            end
            // the terminator needs a slot of its own
            if (ok) begin
                if (enc_count >= capacity_q) begin
                    push_result(8'h00, 1'b1, 1'b1, '0);
                    ok = 1'b0;
                end else begin
                    push_result(8'h00, 1'b1, 1'b0, enc_count);
                end
            end
            clear_message();
        end

        if (!ok) begin
            clear_message();
            enc_dropping = !fin;
        end

        if (exp_results.size() > mark) begin
            last = exp_results.pop_back();
            last.run_end = 1'b1;
            exp_results.push_back(last);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every accepted transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (o_out_data.overflow)
                errors_seen++;
            else if (o_out_data.message_end)
                terms_seen++;
            if (exp_results.size() == 0) begin
                $error("unexpected result: out_char %h message_end %b overflow %b",
                       o_out_data.out_char, o_out_data.message_end, o_out_data.overflow);
                mismatches++;
            end else begin
                want = exp_results.pop_front();
                if (o_out_data.out_char !== want.out_char) begin
                    $error("out_char: expected %h, got %h", want.out_char,
                           o_out_data.out_char);
                    mismatches++;
                end
                if (o_out_data.run_end !== want.run_end) begin
                    $error("run_end: expected %b, got %b", want.run_end,
                           o_out_data.run_end);
                    mismatches++;
                end
                if (o_out_data.message_end !== want.message_end) begin
                    $error("message_end: expected %b, got %b", want.message_end,
                           o_out_data.message_end);
                    mismatches++;
                end
                if (o_out_data.overflow !== want.overflow) begin
                    $error("overflow: expected %b, got %b", want.overflow,
                           o_out_data.overflow);
                    mismatches++;
                end
                if (o_out_data.encoded_length !== want.encoded_length) begin
                    $error("encoded_length: expected %0d, got %0d", want.encoded_length,
                           o_out_data.encoded_length);
                    mismatches++;
                end
            end
        end
    end

    // Receiver stall: random per cycle, or a long hold-off when a test asks for one
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_stall <= 1'b1;
            hold_left   <= hold_left - 1;
        end else if (hold_asked != hold_taken) begin
            i_out_stall <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            hold_taken  <= hold_asked;
        end else begin
            i_out_stall <= ($urandom_range(99) < out_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    // One byte transfer, then an optional idle gap on the input side.
    task automatic send_byte(input logic [7:0] b, input bit fin);
        t_in_item it;
        it.data_byte  = b;
        it.final_byte = fin;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        bytes_sent++;
        if (fin)
            msgs_sent++;
        encode_byte(it);
        if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do
                @(posedge i_clk);
            while ($urandom_range(99) < in_idle_pct);
        end
    endtask

    task automatic send_random_message(input int unsigned len);
        logic [7:0] b;
        for (int unsigned k = 1; k <= len; k++) begin
            b = 8'($urandom_range(255));
            send_byte(b, k == len);
        end
    endtask

    // Input idle until every expected result is back, plus settle time.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        while (exp_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Capacity changes only with the block idle.
    task automatic write_capacity(input logic [LenBits-1:0] v);
        wait_drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        capacity_q = v;
        cfg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_basic_encoding();
        in_idle_pct   = 0;
        out_stall_pct = 0;
        send_byte(8'h00, 1'b1);                       // one byte: flush + two pads
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);                       // two bytes: flush + one pad
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);                       // full quad, no flush
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'hFB, 1'b0);                       // '+' and '/' ends of the alphabet
        send_byte(8'hEF, 1'b0);
        send_byte(8'hBE, 1'b0);
        send_byte(8'hFF, 1'b1);
        wait_drain();
    endtask

    task automatic test_capacity_limits();
        write_capacity(16'd0);     // first write of every message fails
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);    // dropped
        send_byte(8'h56, 1'b1);    // dropped, ends the drop
        send_byte(8'h9A, 1'b1);    // final byte fails, nothing to drop after
        write_capacity(16'd1);     // flush character refused
        send_byte(8'h00, 1'b1);
        write_capacity(16'd4);     // characters fit, terminator slot does not
        send_byte(8'h00, 1'b1);
        write_capacity(16'd5);     // exact fit
        send_byte(8'h00, 1'b1);
        write_capacity(16'd3);     // second char of a phase-2 byte refused mid-transfer
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h04, 1'b1);
        send_byte(8'h05, 1'b1);
        write_capacity(16'hFFFF);
        wait_drain();
    endtask

    task automatic run_random_phase(input int unsigned in_pct, input int unsigned out_pct,
                                    input logic [LenBits-1:0] cap);
        int unsigned start;
        int unsigned len;
        write_capacity(cap);
        in_idle_pct   = in_pct;
        out_stall_pct = out_pct;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_BYTES) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(24, 10) : $urandom_range(9, 1);
            send_random_message(len);
        end
        wait_drain();
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0, 16'hFFFF);
        run_random_phase(50, 0, LenBits'($urandom_range(40, 6)));
        run_random_phase(0, 50, LenBits'($urandom_range(16'hFFFF, 40)));
        run_random_phase(25, 25, LenBits'($urandom_range(12, 0)));
    endtask

    // Receiver holds off while the sender keeps offering; then the sender
    // pauses for a full drain before the last messages.
    task automatic test_backpressure();
        write_capacity(16'hFFFF);
        in_idle_pct   = 0;
        out_stall_pct = 0;
        hold_asked++;
        send_random_message(20);
        wait_drain();
        in_idle_pct   = 25;
        out_stall_pct = 25;
        send_random_message(5);
        send_random_message(3);
        wait_drain();
    endtask

    initial begin
        i_rst_n <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_encoding();
        test_capacity_limits();
        test_random_traffic();
        test_backpressure();

        $display("Run covered %0d bytes in %0d messages, %0d results checked.",
                 bytes_sent, msgs_sent, results_seen);
        $display("  %0d terminators, %0d capacity errors, %0d capacity writes.",
                 terms_seen, errors_seen, cfg_writes);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $error("timeout with %0d results still expected", exp_results.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
